// ===== sv/spr_pkg.sv =====
// Shared types and constants for the sprite span RLE decoder.
// This file has no dependencies. Every other file in the project imports it.
package spr_pkg;

  localparam logic [15:0] MAX_DIM_RESET = 16'd1280;

  typedef enum logic [1:0] {
    KIND_HDR_OK   = 2'd0,
    KIND_HDR_BAD  = 2'd1,
    KIND_PIXEL    = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    PH_WAIT   = 3'd0,
    PH_HEADER = 3'd1,
    PH_ROWCNT = 3'd2,
    PH_SKIP   = 3'd3,
    PH_LITCNT = 3'd4,
    PH_LIT    = 3'd5
  } phase_t;

  typedef enum logic {
    TOK_DATA  = 1'b0,
    TOK_START = 1'b1
  } tok_kind_t;

  typedef struct packed {
    tok_kind_t  kind;
    logic [7:0] data;
  } tok_t;

endpackage

// ===== sv/spr_front.sv =====
// Input stage of the decoder: takes one beat, tags it as frame start or data.
// Depends on spr_pkg. Feeds the token queue (spr_queue).
module spr_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic          frame_start,
  input  logic [7:0]    data_byte,
  input  logic          q_full,
  output logic          push,
  output spr_pkg::tok_t push_tok
);
  import spr_pkg::*;

  logic stage_valid;
  tok_t stage;

  assign push     = stage_valid && !q_full;
  assign push_tok = stage;
  assign in_ready = !stage_valid || !q_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (in_ready) begin
      stage_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      stage.kind <= frame_start ? TOK_START : TOK_DATA;
      stage.data <= data_byte;
    end
  end

endmodule

// ===== sv/spr_queue.sv =====
// Short token queue between the input stage and the decoder core.
// Depends on spr_pkg for the token type.
module spr_queue #(
  parameter int Depth = 4
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  spr_pkg::tok_t push_tok,
  output logic          full,
  input  logic          pop,
  output logic          q_valid,
  output spr_pkg::tok_t q_tok
);
  import spr_pkg::*;

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  tok_t            mem [Depth];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] count;

  assign full    = (count == CntW'(Depth));
  assign q_valid = (count != '0);
  assign q_tok   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_tok;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PtrW'(Depth - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PtrW'(Depth - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== sv/spr_back.sv =====
// Decoder core: header capture, row and group parsing, pixel placement.
// Holds the max_dim register and the result register. Depends on spr_pkg.
module spr_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [15:0]        cfg_data,
  input  logic               q_valid,
  input  spr_pkg::tok_t      q_tok,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         kind,
  output logic [15:0]        pos_x,
  output logic [15:0]        pos_y,
  output logic [7:0]         pixel,
  output logic               in_bounds,
  output logic [15:0]        width,
  output logic [15:0]        height,
  output logic signed [15:0] offset_x,
  output logic signed [15:0] offset_y
);
  import spr_pkg::*;

  logic [15:0] max_dim;
  phase_t      phase, phase_next;
  logic [2:0]  header_index, header_index_next;
  logic [63:0] header_shadow, header_shadow_next;
  logic [7:0]  row_bytes_left, row_bytes_left_next;
  logic [7:0]  literals_left, literals_left_next;
  logic [15:0] cursor_x, cursor_x_next;
  logic [15:0] cursor_y, cursor_y_next;
  logic        first_row_seen, first_row_seen_next;

  logic        emit;
  kind_t       emit_kind;
  logic        emit_inb;
  logic [7:0]  b;
  logic [16:0] sum_x;
  logic [16:0] sum_y;
  logic [7:0]  rows_dec;
  logic [7:0]  lits_dec;
  logic [15:0] hw;
  logic [15:0] hh;

  assign pop = q_valid && (!out_valid || out_ready);
  assign b   = q_tok.data;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_dim <= MAX_DIM_RESET;
    end else if (cfg_we) begin
      max_dim <= cfg_data;
    end
  end

  always_comb begin
    phase_next          = phase;
    header_index_next   = header_index;
    header_shadow_next  = header_shadow;
    row_bytes_left_next = row_bytes_left;
    literals_left_next  = literals_left;
    cursor_x_next       = cursor_x;
    cursor_y_next       = cursor_y;
    first_row_seen_next = first_row_seen;
    emit                = 1'b0;
    emit_kind           = KIND_PIXEL;
    emit_inb            = 1'b0;
    hw                  = header_shadow[15:0];
    hh                  = header_shadow[31:16];
    sum_x               = '0;
    sum_y               = '0;
    rows_dec            = (row_bytes_left != 8'd0) ? row_bytes_left - 8'd1 : 8'd0;
    lits_dec            = (literals_left != 8'd0) ? literals_left - 8'd1 : 8'd0;
    if (pop) begin
      if (q_tok.kind == TOK_START) begin
        header_shadow_next = {56'd0, b};
        header_index_next  = 3'd1;
        phase_next         = PH_HEADER;
      end else begin
        case (phase)
          PH_WAIT: begin
          end
          PH_HEADER: begin
            header_shadow_next[8*header_index +: 8] = b;
            if (header_index != 3'd7) begin
              header_index_next = header_index + 3'd1;
            end else begin
              header_index_next = 3'd0;
              hw   = header_shadow_next[15:0];
              hh   = header_shadow_next[31:16];
              emit = 1'b1;
              if (hw == 16'd0 || hh == 16'd0 || hw > max_dim || hh > max_dim) begin
                phase_next = PH_WAIT;
                emit_kind  = KIND_HDR_BAD;
              end else begin
                phase_next          = PH_ROWCNT;
                emit_kind           = KIND_HDR_OK;
                cursor_x_next       = '0;
                cursor_y_next       = '0;
                row_bytes_left_next = '0;
                literals_left_next  = '0;
                first_row_seen_next = 1'b0;
              end
            end
          end
          PH_ROWCNT: begin
            if (first_row_seen) begin
              sum_y         = {1'b0, cursor_y} + 17'd1;
              cursor_y_next = sum_y[16] ? 16'hFFFF : sum_y[15:0];
            end
            first_row_seen_next = 1'b1;
            cursor_x_next       = '0;
            row_bytes_left_next = b;
            phase_next          = (b == 8'd0) ? PH_ROWCNT : PH_SKIP;
          end
          PH_SKIP: begin
            sum_x               = {1'b0, cursor_x} + {9'd0, b};
            cursor_x_next       = sum_x[16] ? 16'hFFFF : sum_x[15:0];
            row_bytes_left_next = rows_dec;
            phase_next          = PH_LITCNT;
          end
          PH_LITCNT: begin
            row_bytes_left_next = rows_dec;
            literals_left_next  = b;
            if (b == 8'd0) begin
              phase_next = (rows_dec == 8'd0) ? PH_ROWCNT : PH_SKIP;
            end else begin
              phase_next = PH_LIT;
            end
          end
          PH_LIT: begin
            emit                = 1'b1;
            emit_kind           = KIND_PIXEL;
            emit_inb            = (cursor_x < hw) && (cursor_y < hh);
            sum_x               = {1'b0, cursor_x} + 17'd1;
            cursor_x_next       = sum_x[16] ? 16'hFFFF : sum_x[15:0];
            row_bytes_left_next = rows_dec;
            literals_left_next  = lits_dec;
            if (lits_dec == 8'd0) begin
              phase_next = (rows_dec == 8'd0) ? PH_ROWCNT : PH_SKIP;
            end
          end
          default: begin
            phase_next = PH_WAIT;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_WAIT;
      header_index   <= '0;
      header_shadow  <= '0;
      row_bytes_left <= '0;
      literals_left  <= '0;
      cursor_x       <= '0;
      cursor_y       <= '0;
      first_row_seen <= 1'b0;
      out_valid      <= 1'b0;
    end else begin
      phase          <= phase_next;
      header_index   <= header_index_next;
      header_shadow  <= header_shadow_next;
      row_bytes_left <= row_bytes_left_next;
      literals_left  <= literals_left_next;
      cursor_x       <= cursor_x_next;
      cursor_y       <= cursor_y_next;
      first_row_seen <= first_row_seen_next;
      if (pop && emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop && emit) begin
      kind      <= emit_kind;
      pos_x     <= (emit_kind == KIND_PIXEL) ? cursor_x : 16'd0;
      pos_y     <= (emit_kind == KIND_PIXEL) ? cursor_y : 16'd0;
      pixel     <= (emit_kind == KIND_PIXEL) ? b : 8'd0;
      in_bounds <= emit_inb;
      width     <= header_shadow_next[15:0];
      height    <= header_shadow_next[31:16];
      offset_x  <= signed'(header_shadow_next[47:32]);
      offset_y  <= signed'(header_shadow_next[63:48]);
    end
  end

endmodule

// ===== sv/sprite_span_rle_decoder.sv =====
// Top level of the sprite span RLE decoder: input stage, token queue, decoder core.
// Depends on spr_pkg, spr_front, spr_queue and spr_back.
//
// The block takes one frame byte per beat and sustains one beat per cycle
// while the result side keeps up: the decoder core updates its parse state
// for one byte in a single cycle, and a result register parts it from the
// output handshake. A byte is registered in the input stage, then in the
// token queue, then in the core's result register. A header beat yields a
// header result at its eighth byte, a literal byte yields a pixel result,
// and all other bytes yield nothing. max_dim resets to 1280. The user must
// write it with cfg_we only while the block is idle; the block does not enforce it.
module sprite_span_rle_decoder #(
  parameter int QueueDepth = 4
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [15:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               frame_start,
  input  logic [7:0]         data_byte,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         kind,
  output logic [15:0]        pos_x,
  output logic [15:0]        pos_y,
  output logic [7:0]         pixel,
  output logic               in_bounds,
  output logic [15:0]        width,
  output logic [15:0]        height,
  output logic signed [15:0] offset_x,
  output logic signed [15:0] offset_y
);
  import spr_pkg::*;

  logic q_full;
  logic push;
  tok_t push_tok;
  logic pop;
  logic q_valid;
  tok_t q_tok;

  spr_front u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .frame_start (frame_start),
    .data_byte   (data_byte),
    .q_full      (q_full),
    .push        (push),
    .push_tok    (push_tok)
  );

  spr_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_tok (push_tok),
    .full     (q_full),
    .pop      (pop),
    .q_valid  (q_valid),
    .q_tok    (q_tok)
  );

  spr_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .q_valid   (q_valid),
    .q_tok     (q_tok),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .kind      (kind),
    .pos_x     (pos_x),
    .pos_y     (pos_y),
    .pixel     (pixel),
    .in_bounds (in_bounds),
    .width     (width),
    .height    (height),
    .offset_x  (offset_x),
    .offset_y  (offset_y)
  );

endmodule

// ===== sv/spr_checker.sv =====
// Port-level checks on the results of the sprite span RLE decoder.
// Depends on spr_pkg. The bind at the end attaches it to the top level.
module spr_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  kind,
  input logic [15:0] pos_x,
  input logic [15:0] pos_y,
  input logic [7:0]  pixel,
  input logic        in_bounds,
  input logic [15:0] width,
  input logic [15:0] height
);
  import spr_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(kind) && $stable(pos_x) &&
      $stable(pos_y) && $stable(pixel))
    else $error("result beat changed while stalled");

  a_inb: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind == KIND_PIXEL && in_bounds |-> pos_x < width && pos_y < height)
    else $error("in-bounds pixel lies outside the frame");

  a_hdr_ok: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind == KIND_HDR_OK |-> width != 16'd0 && height != 16'd0 &&
      pos_x == 16'd0 && pos_y == 16'd0 && pixel == 8'd0 && !in_bounds)
    else $error("accepted header result is malformed");

  a_hdr_bad: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind == KIND_HDR_BAD |-> pos_x == 16'd0 && pos_y == 16'd0 &&
      pixel == 8'd0 && !in_bounds)
    else $error("rejected header result carries pixel data");

endmodule

bind sprite_span_rle_decoder spr_checker u_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .kind      (kind),
  .pos_x     (pos_x),
  .pos_y     (pos_y),
  .pixel     (pixel),
  .in_bounds (in_bounds),
  .width     (width),
  .height    (height)
);
